// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the RTL of the pair energy core.
// Depends on nothing; define SYNTH to drop all checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
`define A_IMPL(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("assertion failed");
`define A_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define A_IMPL(lbl, clk, rstn, ante, cons)
`define A_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

// ===== hdl/ljea_pkg.sv =====
// Package of the pair energy core: widths, register indexes, states.
// Depends on nothing.
`default_nettype none
package ljea_pkg;
    localparam int INDEX_BITS = 16;
    localparam int ADDR_BITS  = 6;
    localparam logic [2:0] REG_DOMAIN = 3'd0;
    localparam logic [2:0] REG_MODE   = 3'd1;
    localparam logic [2:0] REG_CUTOFF = 3'd2;
    localparam logic [2:0] REG_SIGMA  = 3'd3;
    localparam logic [2:0] REG_DEPTH  = 3'd4;
    localparam logic [1:0] MODE_NOWRAP = 2'd1;
    localparam logic [63:0] ONE  = 64'h1_0000_0000;
    localparam logic [63:0] MAXS = 64'h7FFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [30:0] domain_length;
        logic [1:0]  boundary_mode;
        logic [62:0] cutoff_squared;
        logic [62:0] sigma_squared;
        logic [30:0] well_depth;
    } t_cfg;

    typedef struct packed {
        logic        start;
        logic [63:0] a;
        logic [63:0] b;
    } t_mul_req;

    typedef enum logic [11:0] {
        S_IDLE = 12'b000000000001,
        S_DIST = 12'b000000000010,
        S_SQX  = 12'b000000000100,
        S_SQY  = 12'b000000001000,
        S_CUT  = 12'b000000010000,
        S_DIV  = 12'b000000100000,
        S_M1   = 12'b000001000000,
        S_M2   = 12'b000010000000,
        S_M3   = 12'b000100000000,
        S_M4   = 12'b001000000000,
        S_ACC  = 12'b010000000000,
        S_OUT  = 12'b100000000000
    } t_state;
endpackage
`default_nettype wire

// ===== hdl/ljea_if.sv =====
// Valid/ready channel interfaces for input and result words.
// Depends on nothing.
`default_nettype none
interface ljea_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] self_x;
    logic [31:0] self_y;
    logic [31:0] neighbor_x;
    logic [31:0] neighbor_y;
    logic [15:0] self_index;
    logic [15:0] neighbor_index;
    logic        pair_present;
    logic        last_neighbor;
    logic        last_particle;
    modport source (output valid, self_x, self_y, neighbor_x, neighbor_y, self_index,
                    neighbor_index, pair_present, last_neighbor, last_particle,
                    input ready);
    modport sink (input valid, self_x, self_y, neighbor_x, neighbor_y, self_index,
                  neighbor_index, pair_present, last_neighbor, last_particle,
                  output ready);
endinterface

interface ljea_out_if;
    logic        valid;
    logic        ready;
    logic [63:0] particle_energy;
    logic [63:0] half_total_energy;
    logic        system_done;
    logic        saturated;
    modport source (output valid, particle_energy, half_total_energy, system_done,
                    saturated, input ready);
    modport sink (input valid, particle_energy, half_total_energy, system_done,
                  saturated, output ready);
endinterface
`default_nettype wire

// ===== hdl/ljea_div.sv =====
// Restoring divider, one quotient bit a cycle: floor(num * 2^32 / den).
// Depends on nothing; plain logic only.
`default_nettype none
module ljea_div (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_start,
    input  wire logic [62:0] i_num,
    input  wire logic [63:0] i_den,
    output logic             o_done,
    output logic [63:0]      o_quot
);
    logic [63:0] r_rem, n_rem;
    logic [63:0] r_low, r_q;
    logic [63:0] r_den;
    logic [6:0]  r_cnt;
    logic        r_busy;
    logic [64:0] w_sh;

    assign w_sh  = {r_rem, r_low[63]};
    assign n_rem = (w_sh >= {1'b0, r_den}) ? 64'(w_sh - {1'b0, r_den}) : w_sh[63:0];

    // shift one numerator bit in per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_start) begin
                r_rem  <= {33'd0, i_num[62:32]};
                r_low  <= {i_num[31:0], 32'd0};
                r_den  <= i_den;
                r_q    <= '0;
                r_cnt  <= 7'd0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_rem <= n_rem;
                r_low <= {r_low[62:0], 1'b0};
                r_q   <= {r_q[62:0], w_sh >= {1'b0, r_den}};
                r_cnt <= r_cnt + 7'd1;
                if (r_cnt == 7'd63) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_quot = r_q;
endmodule
`default_nettype wire

// ===== hdl/ljea_mul.sv =====
// Serial 64x64 multiplier, one 16-bit digit of b per cycle, full product.
// Depends on ljea_pkg for the request struct and on assert_macros.svh.
`default_nettype none
`include "assert_macros.svh"
module ljea_mul (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire ljea_pkg::t_mul_req i_req,
    output logic                   o_done,
    output logic [127:0]           o_prod
);
    logic [63:0]  r_a, r_b;
    logic [127:0] r_acc;
    logic [2:0]   r_cnt;
    logic         r_busy;
    logic [79:0]  w_pp;

    assign w_pp = r_a * {64'd0, r_b[15:0]};

    // add one shifted partial product per cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            o_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_a    <= i_req.a;
                r_b    <= i_req.b;
                r_acc  <= '0;
                r_cnt  <= '0;
                r_busy <= 1'b1;
            end else if (r_busy) begin
                r_acc <= {16'd0, r_acc[127:16]} + {w_pp, 48'd0};
                r_b   <= {16'd0, r_b[63:16]};
                r_cnt <= r_cnt + 3'd1;
                if (r_cnt == 3'd3) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end
    assign o_prod = r_acc;

    `A_NEXT(a_mul_done_one, i_clk, i_rst_n, o_done, !o_done)
endmodule
`default_nettype wire

// ===== hdl/lennard_jones_energy_accumulate_core.sv =====
// Lennard-Jones pair energy core.
// Input words arrive on in_ch, one pair each, valid/ready, accepted when
// both are high. One word is processed at a time.
// A skipped pair goes from idle straight to the accumulate state; a pair whose
// distance does not fit 32 bits passes the distance state first; a pair beyond
// the cutoff also passes two serial squares and the cutoff test; a pair inside
// the cutoff then runs the 64-step serial divider and four serial 64x64
// multiplies (one 16-bit digit a cycle). A saturated quotient skips the
// divider. The next word is accepted once the core is back in idle.
// On a word with last_neighbor the particle energy, half of the running
// system total, system_done and saturated are loaded into an output
// register, valid the cycle after; while the receiver stalls the core
// holds the word and takes no input.
// Registers are to be written through the APB-style port only while idle;
// the core itself does not enforce it. Reads return the register value.
// Reset clears sums, the saturation-seen flag and registers (boundary mode
// becomes wrap x and y) and takes effect on the next clock.
`default_nettype none
`include "assert_macros.svh"
module lennard_jones_energy_accumulate_core (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [5:0]  paddr,
    input  wire logic [63:0] pwdata,
    output logic [63:0]      prdata,
    output logic             pready,
    ljea_in_if.sink          in_ch,
    ljea_out_if.source       out_ch
);
    ljea_pkg::t_cfg   r_cfg;
    ljea_pkg::t_state r_st;
    ljea_pkg::t_mul_req w_req;
    logic [2:0] w_idx;
    logic [63:0] r_dx, r_dy, r_d2, r_r2, r_t, r_r6, r_pm;
    logic r_neg, r_sat, r_lastn, r_lastp, r_sseen;
    logic signed [63:0] r_psum, r_ssum;
    logic w_div_done, w_mul_done;
    logic [63:0] w_quot;
    logic [127:0] w_prod;
    logic r_div_go;
    logic [63:0] r_pe, r_he;
    logic r_sd, r_so;

    assign pready = 1'b1;
    assign w_idx = paddr[5:3];

    // register reads
    always_comb begin
        case (w_idx)
            ljea_pkg::REG_DOMAIN: prdata = {33'd0, r_cfg.domain_length};
            ljea_pkg::REG_MODE:   prdata = {62'd0, r_cfg.boundary_mode};
            ljea_pkg::REG_CUTOFF: prdata = {1'b0, r_cfg.cutoff_squared};
            ljea_pkg::REG_SIGMA:  prdata = {1'b0, r_cfg.sigma_squared};
            ljea_pkg::REG_DEPTH:  prdata = {33'd0, r_cfg.well_depth};
            default:              prdata = '0;
        endcase
    end

    // wrap one delta by the domain length
    function automatic logic [63:0] wrap(input logic [63:0] d, input logic [30:0] len);
        logic signed [63:0] s, l;
        s = $signed(d);
        l = $signed({33'd0, len});
        if ((s <<< 1) > l) s = s - l;
        if ((s <<< 1) < -l) s = s + l;
        return s;
    endfunction

    function automatic logic [63:0] absv(input logic [63:0] d);
        return d[63] ? 64'(-d) : d;
    endfunction

    // saturating signed add
    function automatic logic [64:0] sadd(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (!a[63] && !b[63] && s[63]) return {1'b1, ljea_pkg::MAXS};
        if (a[63] && b[63] && !s[63]) return {1'b1, ~ljea_pkg::MAXS};
        return {1'b0, s};
    endfunction

    // multiplier operand selection by state
    always_comb begin
        w_req.start = 1'b0;
        w_req.a = r_dx;
        w_req.b = r_dx;
        case (r_st)
            ljea_pkg::S_SQY: begin w_req.a = r_dy; w_req.b = r_dy; end
            ljea_pkg::S_M1: begin w_req.a = r_r2; w_req.b = r_r2; end
            ljea_pkg::S_M2: begin w_req.a = r_t;  w_req.b = r_r2; end
            ljea_pkg::S_M3: begin
                w_req.a = r_r6;
                w_req.b = r_neg ? 64'(ljea_pkg::ONE - r_r6) : 64'(r_r6 - ljea_pkg::ONE);
            end
            ljea_pkg::S_M4: begin w_req.a = {33'd0, r_cfg.well_depth}; w_req.b = r_pm; end
            default: ;
        endcase
        w_req.start = r_div_go && ((r_st == ljea_pkg::S_SQX) || (r_st == ljea_pkg::S_SQY)
                      || (r_st == ljea_pkg::S_M1) || (r_st == ljea_pkg::S_M2)
                      || (r_st == ljea_pkg::S_M3) || (r_st == ljea_pkg::S_M4));
    end

    ljea_div u_div (.i_clk(i_clk), .i_rst_n(i_rst_n),
                    .i_start(r_div_go && r_st == ljea_pkg::S_DIV),
                    .i_num(r_cfg.sigma_squared), .i_den(r_d2),
                    .o_done(w_div_done), .o_quot(w_quot));
    ljea_mul u_mul (.i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(w_req),
                    .o_done(w_mul_done), .o_prod(w_prod));

    // q32 product capped at a limit
    function automatic logic [64:0] mq(input logic [127:0] p, input logic [63:0] lim);
        if (p[127:96] != 0 || p[95:32] > lim) return {1'b1, lim};
        return {1'b0, p[95:32]};
    endfunction

    assign in_ch.ready = (r_st == ljea_pkg::S_IDLE);
    assign out_ch.valid = (r_st == ljea_pkg::S_OUT);
    assign out_ch.particle_energy = r_pe;
    assign out_ch.half_total_energy = r_he;
    assign out_ch.system_done = r_sd;
    assign out_ch.saturated = r_so;

    // sequencer
    always_ff @(posedge i_clk) begin
        logic [64:0] m;
        logic [63:0] sx, sy, tm;
        logic [64:0] s2;
        logic [64:0] ps, ss;
        if (!i_rst_n) begin
            r_cfg <= '{domain_length: '0, boundary_mode: 2'd2, cutoff_squared: '0,
                       sigma_squared: '0, well_depth: '0};
            r_st <= ljea_pkg::S_IDLE;
            r_psum <= '0;
            r_ssum <= '0;
            r_sseen <= 1'b0;
            r_div_go <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                case (w_idx)
                    ljea_pkg::REG_DOMAIN: r_cfg.domain_length <= pwdata[30:0];
                    ljea_pkg::REG_MODE:   r_cfg.boundary_mode <= pwdata[1:0];
                    ljea_pkg::REG_CUTOFF: r_cfg.cutoff_squared <= pwdata[62:0];
                    ljea_pkg::REG_SIGMA:  r_cfg.sigma_squared <= pwdata[62:0];
                    ljea_pkg::REG_DEPTH:  r_cfg.well_depth <= pwdata[30:0];
                    default: ;
                endcase
            end
            r_div_go <= 1'b0;
            case (r_st)
                ljea_pkg::S_IDLE: if (in_ch.valid) begin
                    r_lastn <= in_ch.last_neighbor;
                    r_lastp <= in_ch.last_particle;
                    r_sat <= 1'b0;
                    r_dx <= 64'($signed(in_ch.neighbor_x)) - 64'($signed(in_ch.self_x));
                    r_dy <= 64'($signed(in_ch.neighbor_y)) - 64'($signed(in_ch.self_y));
                    if (in_ch.pair_present && in_ch.self_index[ljea_pkg::INDEX_BITS-1:0]
                        != in_ch.neighbor_index[ljea_pkg::INDEX_BITS-1:0])
                        r_st <= ljea_pkg::S_DIST;
                    else
                        r_st <= ljea_pkg::S_ACC;
                end
                // wrap and take magnitudes; a delta of 2^32 or more is beyond any cutoff
                ljea_pkg::S_DIST: begin
                    sx = (r_cfg.boundary_mode != ljea_pkg::MODE_NOWRAP) ?
                         absv(wrap(r_dx, r_cfg.domain_length)) : absv(r_dx);
                    sy = r_cfg.boundary_mode[1] ? absv(wrap(r_dy, r_cfg.domain_length))
                                                : absv(r_dy);
                    r_dx <= sx;
                    r_dy <= sy;
                    if (sx[63:32] != 0 || sy[63:32] != 0) r_st <= ljea_pkg::S_ACC;
                    else begin
                        r_st <= ljea_pkg::S_SQX;
                        r_div_go <= 1'b1;
                    end
                end
                ljea_pkg::S_SQX: if (w_mul_done) begin
                    r_d2 <= w_prod[63:0];
                    r_st <= ljea_pkg::S_SQY;
                    r_div_go <= 1'b1;
                end
                // add the y square, saturate on carry
                ljea_pkg::S_SQY: if (w_mul_done) begin
                    s2 = {1'b0, r_d2} + {1'b0, w_prod[63:0]};
                    r_d2 <= s2[64] ? '1 : s2[63:0];
                    r_st <= ljea_pkg::S_CUT;
                end
                // cutoff test and quotient saturation check
                ljea_pkg::S_CUT: begin
                    if (r_d2 < {1'b0, r_cfg.cutoff_squared}) begin
                        if (r_d2 == 0 || {33'd0, r_cfg.sigma_squared[62:32]} >= r_d2) begin
                            r_sat <= 1'b1;
                            r_r2 <= '1;
                            r_st <= ljea_pkg::S_M1;
                            r_div_go <= 1'b1;
                        end else begin
                            r_st <= ljea_pkg::S_DIV;
                            r_div_go <= 1'b1;
                        end
                    end else r_st <= ljea_pkg::S_ACC;
                end
                ljea_pkg::S_DIV: if (w_div_done) begin
                    r_r2 <= w_quot;
                    r_st <= ljea_pkg::S_M1;
                    r_div_go <= 1'b1;
                end
                ljea_pkg::S_M1: if (w_mul_done) begin
                    m = mq(w_prod, '1);
                    r_t <= m[63:0]; r_sat <= r_sat | m[64];
                    r_st <= ljea_pkg::S_M2; r_div_go <= 1'b1;
                end
                ljea_pkg::S_M2: if (w_mul_done) begin
                    m = mq(w_prod, ljea_pkg::MAXS);
                    r_r6 <= m[63:0]; r_sat <= r_sat | m[64];
                    r_neg <= (m[63:0] < ljea_pkg::ONE);
                    r_st <= ljea_pkg::S_M3; r_div_go <= 1'b1;
                end
                ljea_pkg::S_M3: if (w_mul_done) begin
                    m = mq(w_prod, ljea_pkg::MAXS);
                    r_pm <= m[63:0]; r_sat <= r_sat | m[64];
                    r_st <= ljea_pkg::S_M4; r_div_go <= 1'b1;
                end
                ljea_pkg::S_M4: if (w_mul_done) begin
                    m = mq(w_prod, ljea_pkg::MAXS);
                    tm = r_neg ? 64'(-m[63:0]) : m[63:0];
                    ps = sadd(r_psum, tm);
                    r_psum <= ps[63:0];
                    r_sseen <= r_sseen | r_sat | m[64] | ps[64];
                    r_st <= ljea_pkg::S_ACC;
                end
                ljea_pkg::S_ACC: begin
                    if (r_lastn) begin
                        ss = sadd(r_ssum, r_psum);
                        r_pe <= r_psum;
                        r_he <= 64'($signed(ss[63:0]) / 2);
                        r_sd <= r_lastp;
                        r_so <= r_sseen | ss[64];
                        r_ssum <= r_lastp ? '0 : $signed(ss[63:0]);
                        r_psum <= '0;
                        r_sseen <= 1'b0;
                        r_st <= ljea_pkg::S_OUT;
                    end else r_st <= ljea_pkg::S_IDLE;
                end
                ljea_pkg::S_OUT: if (out_ch.ready) r_st <= ljea_pkg::S_IDLE;
                default: r_st <= ljea_pkg::S_IDLE;
            endcase
        end
    end

    `A_IMPL(a_no_in_while_out, i_clk, i_rst_n, out_ch.valid, !in_ch.ready)
    `A_NEXT(a_out_holds, i_clk, i_rst_n, out_ch.valid && !out_ch.ready,
            out_ch.valid && $stable(r_pe))
    `A_NEXT(a_psum_clear, i_clk, i_rst_n, r_st == ljea_pkg::S_ACC && r_lastn,
            r_psum == 0 && !r_sseen)
endmodule
`default_nettype wire

// ===== tb/sv/tb_lennard_jones_energy_accumulate_core.sv =====
// Testbench of the Lennard-Jones pair energy core: drives neighbour words,
// predicts particle and system energies and checks every result word.
// Depends on ljea_pkg, the ljea_in_if/ljea_out_if interfaces and the core.
`default_nettype none
module tb_lennard_jones_energy_accumulate_core;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int          CYCLE_LIMIT = 3_000_000;
    localparam int          SETTLE_CYCLES = 200;
    localparam longint      I64_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam longint      I64_MIN = 64'sh8000_0000_0000_0000;
    localparam logic [63:0] ONE_Q32 = 64'h1_0000_0000;

    typedef struct {
        logic [63:0] energy;
        logic [63:0] half_total;
        logic        done;
        logic        sat;
    } t_energy_word;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [5:0]  paddr = '0;
    logic [63:0] pwdata = '0;
    logic [63:0] prdata;
    logic        pready;

    ljea_in_if  in_ch();
    ljea_out_if out_ch();

    lennard_jones_energy_accumulate_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .in_ch(in_ch), .out_ch(out_ch)
    );

    // Predictor copy of registers and accumulators
    logic [63:0] m_domain, m_cutoff, m_sigma, m_depth;
    logic [1:0]  m_mode;
    longint      m_particle_sum, m_system_sum;
    bit          m_sat_seen;

    t_energy_word energy_q[$];
    int  error_count = 0;
    int  cycle_count = 0;
    int  src_idle_pct = 0;
    int  snk_stall_pct = 0;
    bit  hold_req = 0;
    int  hold_left = 0;
    int  items_sent = 0;

    always #1 i_clk = ~i_clk;

    // Abort on a hung run
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic report_mismatch(input string what, input logic [63:0] got,
                                   input logic [63:0] want);
        error_count++;
        $display("mismatch %s: got %h want %h at cycle %0d", what, got, want, cycle_count);
    endtask

    // (a*b)>>32, capped at lim
    function automatic logic [63:0] mul_q32(input logic [63:0] a, input logic [63:0] b,
                                            input logic [63:0] lim, inout bit sat);
        logic [127:0] p;
        p = {64'b0, a} * {64'b0, b};
        if (p[127:96] != 0) begin
            sat = 1;
            return lim;
        end
        if (p[95:32] > lim) begin
            sat = 1;
            return lim;
        end
        return p[95:32];
    endfunction

    // floor(num*2^32/d), capped
    function automatic logic [63:0] div_q32(input logic [63:0] num, input logic [63:0] d,
                                            inout bit sat);
        logic [127:0] q;
        if ((num >> 32) >= d) begin
            sat = 1;
            return '1;
        end
        q = {32'b0, num, 32'b0} / {64'b0, d};
        return q[63:0];
    endfunction

    function automatic longint add_sat(input longint a, input longint b, inout bit sat);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat = 1;
            return (b > 0) ? I64_MAX : I64_MIN;
        end
        return s[63:0];
    endfunction

    function automatic longint min_image(input longint d);
        longint len;
        len = longint'(m_domain);
        if (2 * d > len) d -= len;
        if (2 * d < -len) d += len;
        return d;
    endfunction

    function automatic longint lj_term(input logic [63:0] d2, inout bit sat);
        logic [63:0] r2, t, r6, pm, mag;
        bit neg;
        if (d2 == 0) begin
            sat = 1;
            r2 = '1;
        end else begin
            r2 = div_q32(m_sigma, d2, sat);
        end
        t = mul_q32(r2, r2, '1, sat);
        r6 = mul_q32(t, r2, I64_MAX, sat);
        neg = (r6 < ONE_Q32);
        pm = neg ? mul_q32(r6, ONE_Q32 - r6, I64_MAX, sat)
                 : mul_q32(r6, r6 - ONE_Q32, I64_MAX, sat);
        mag = mul_q32(m_depth, pm, I64_MAX, sat);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    // Advance predictor by one accepted word
    task automatic predict_energy(input logic [31:0] sx, input logic [31:0] sy,
                                  input logic [31:0] nx, input logic [31:0] ny,
                                  input logic [15:0] si, input logic [15:0] ni,
                                  input logic pres, input logic lastn, input logic lastp);
        longint dx, dy;
        logic [63:0] mx, my, d2;
        logic [64:0] s2;
        bit big, sat;
        t_energy_word w;
        if (pres && si[ljea_pkg::INDEX_BITS-1:0] != ni[ljea_pkg::INDEX_BITS-1:0]) begin
            dx = longint'($signed(nx)) - longint'($signed(sx));
            dy = longint'($signed(ny)) - longint'($signed(sy));
            if (m_mode != ljea_pkg::MODE_NOWRAP) dx = min_image(dx);
            if (m_mode >= 2) dy = min_image(dy);
            mx = (dx < 0) ? -dx : dx;
            my = (dy < 0) ? -dy : dy;
            big = (mx >= ONE_Q32) || (my >= ONE_Q32);
            s2 = {1'b0, mx * mx} + {1'b0, my * my};
            d2 = (big || s2[64]) ? '1 : s2[63:0];
            if (d2 < m_cutoff) begin
                sat = 0;
                m_particle_sum = add_sat(m_particle_sum, lj_term(d2, sat), sat);
                if (sat) m_sat_seen = 1;
            end
        end
        if (lastn) begin
            sat = m_sat_seen;
            m_system_sum = add_sat(m_system_sum, m_particle_sum, sat);
            w.energy = m_particle_sum;
            w.half_total = m_system_sum / 2;
            w.done = lastp;
            w.sat = sat;
            energy_q.push_back(w);
            m_particle_sum = 0;
            m_sat_seen = 0;
            if (lastp) m_system_sum = 0;
        end
    endtask

    // Offer one word, wait for acceptance
    task automatic send_pair(input logic [31:0] sx, input logic [31:0] sy,
                             input logic [31:0] nx, input logic [31:0] ny,
                             input logic [15:0] si, input logic [15:0] ni,
                             input logic pres, input logic lastn, input logic lastp);
        if ($urandom_range(99) < src_idle_pct) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(6, 1)) @(posedge i_clk);
        end
        in_ch.valid <= 1'b1;
        in_ch.self_x <= sx;
        in_ch.self_y <= sy;
        in_ch.neighbor_x <= nx;
        in_ch.neighbor_y <= ny;
        in_ch.self_index <= si;
        in_ch.neighbor_index <= ni;
        in_ch.pair_present <= pres;
        in_ch.last_neighbor <= lastn;
        in_ch.last_particle <= lastp;
        do @(posedge i_clk); while (!in_ch.ready);
        predict_energy(sx, sy, nx, ny, si, ni, pres, lastn, lastp);
        items_sent++;
    endtask

    // Drop valid, wait for all results and for the core to go quiet
    task automatic drain_results();
        in_ch.valid <= 1'b0;
        while (energy_q.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [2:0] idx, input logic [63:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= {idx, 3'b000};
        pwdata <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        case (idx)
            ljea_pkg::REG_DOMAIN: m_domain = val & 64'h7FFF_FFFF;
            ljea_pkg::REG_MODE:   m_mode = val[1:0];
            ljea_pkg::REG_CUTOFF: m_cutoff = val & 64'h7FFF_FFFF_FFFF_FFFF;
            ljea_pkg::REG_SIGMA:  m_sigma = val & 64'h7FFF_FFFF_FFFF_FFFF;
            ljea_pkg::REG_DEPTH:  m_depth = val & 64'h7FFF_FFFF;
            default: ;
        endcase
    endtask

    task automatic load_config(input logic [63:0] len, input logic [1:0] mode,
                               input logic [63:0] cut, input logic [63:0] sig,
                               input logic [63:0] eps);
        write_reg(ljea_pkg::REG_DOMAIN, len);
        write_reg(ljea_pkg::REG_MODE, {62'b0, mode});
        write_reg(ljea_pkg::REG_CUTOFF, cut);
        write_reg(ljea_pkg::REG_SIGMA, sig);
        write_reg(ljea_pkg::REG_DEPTH, eps);
    endtask

    // Typical setup: L = 10, sigma = 1, cutoff 2.5 sigma, epsilon = 1
    task automatic load_typical(input logic [1:0] mode);
        load_config(64'd10 << 16, mode, 64'd25 << 30, ONE_Q32, 64'd1 << 16);
    endtask

    // Well-formed particles with random neighbour lists; some noise words
    task automatic send_particles(input int n_items, input int span);
        int left, nb, k, off_x, off_y, r;
        logic [31:0] sx, sy, nx, ny;
        logic [15:0] si, ni;
        logic pres, lastp;
        left = n_items;
        while (left > 0) begin
            sx = $urandom_range(2 * span) - span;
            sy = $urandom_range(2 * span) - span;
            si = 16'($urandom);
            nb = $urandom_range(8, 1);
            lastp = ($urandom_range(3) == 0);
            for (k = 0; k < nb; k++) begin
                r = $urandom_range(99);
                off_x = $urandom_range(2 * span) - span;
                off_y = $urandom_range(2 * span) - span;
                nx = sx + off_x;
                ny = sy + off_y;
                ni = 16'($urandom);
                pres = (r >= 5);
                if (r >= 5 && r < 10) ni = si;
                if (r >= 10 && r < 13) begin
                    nx = $urandom;
                    ny = $urandom;
                end
                if (r >= 13 && r < 15) begin
                    nx = sx;
                    ny = sy;
                end
                if (r >= 15 && r < 18) ni = {8'($urandom_range(255)), si[7:0]} ^ 16'h0100;
                send_pair(sx, sy, nx, ny, si, ni, pres, k == nb - 1, lastp && k == nb - 1);
            end
            left -= nb;
        end
    endtask

    // Long receiver hold, counted in its own process
    always @(posedge i_clk) begin
        if (hold_req) begin
            hold_req = 0;
            hold_left <= 600;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end
    end

    // Result side: random stall, long hold on request, compare against oldest
    always @(posedge i_clk) begin
        t_energy_word w;
        if (out_ch.valid && out_ch.ready) begin
            if (energy_q.size() == 0) begin
                report_mismatch("unexpected word", out_ch.particle_energy, '0);
            end else begin
                w = energy_q.pop_front();
                if (out_ch.particle_energy !== w.energy)
                    report_mismatch("particle_energy", out_ch.particle_energy, w.energy);
                if (out_ch.half_total_energy !== w.half_total)
                    report_mismatch("half_total_energy", out_ch.half_total_energy,
                                    w.half_total);
                if (out_ch.system_done !== w.done)
                    report_mismatch("system_done", out_ch.system_done, w.done);
                if (out_ch.saturated !== w.sat)
                    report_mismatch("saturated", out_ch.saturated, w.sat);
            end
        end
        if (hold_left > 0) begin
            out_ch.ready <= 1'b0;
        end else begin
            out_ch.ready <= ($urandom_range(99) >= snk_stall_pct);
        end
    end

    task automatic test_reset_values();
        // Defaults: cutoff zero, nothing accumulates
        send_pair(32'h0001_0000, 0, 0, 0, 1, 2, 1, 0, 0);
        send_pair(0, 0, 0, 0, 1, 3, 1, 1, 0);
        send_pair(0, 0, 32'h0000_8000, 0, 4, 5, 1, 1, 1);
        drain_results();
    endtask

    task automatic test_directed();
        load_typical(2);
        // Field extremes, skips, zero distance, wrap edges
        send_pair(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF,
                  16'h0000, 16'hFFFF, 1, 0, 0);
        send_pair(32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF,
                  16'hFFFF, 16'h0000, 1, 1, 0);
        send_pair(0, 0, 32'h0001_0000, 0, 7, 7, 1, 0, 0);
        send_pair(0, 0, 32'h0001_0000, 0, 7, 8, 0, 1, 0);
        send_pair(0, 0, 0, 0, 9, 10, 1, 1, 0);
        send_pair(0, 0, 32'h0001_2000, 0, 11, 12, 1, 0, 0);
        send_pair(0, 0, 32'h0000_E000, 32'h0000_4000, 11, 13, 1, 0, 0);
        send_pair(0, 0, 32'h0005_0000, 0, 11, 14, 1, 0, 0);
        send_pair(0, 0, 32'h0009_8000, 0, 11, 15, 1, 0, 0);
        send_pair(0, 0, 0, 32'hFFF6_8000, 11, 16, 1, 0, 0);
        send_pair(0, 0, 32'h0001_9000, 0, 11, 17, 1, 0, 0);
        send_pair(0, 0, 32'h0000_0001, 0, 11, 18, 1, 1, 1);
        send_pair(0, 0, 0, 0, 20, 21, 0, 1, 1);
        drain_results();
        // Maximum settings: everything saturates
        load_config(64'h7FFF_FFFF, 2, 64'h7FFF_FFFF_FFFF_FFFF, 64'h7FFF_FFFF_FFFF_FFFF,
                    64'h7FFF_FFFF);
        send_pair(0, 0, 32'h0000_0100, 0, 1, 2, 1, 0, 0);
        send_pair(0, 0, 32'h0000_0100, 0, 1, 3, 1, 1, 0);
        send_pair(0, 0, 32'h0000_0200, 32'h0000_0100, 4, 5, 1, 1, 0);
        send_pair(32'h8000_0000, 0, 32'h7FFF_FFFF, 0, 6, 7, 1, 1, 1);
        drain_results();
    endtask

    task automatic test_boundary_modes();
        int mode;
        for (mode = 0; mode < 4; mode++) begin
            load_typical(mode[1:0]);
            send_particles(90, 6 << 16);
            drain_results();
        end
    endtask

    task automatic test_register_extremes();
        load_config(64'h7FFF_FFFF, 2, 64'h7FFF_FFFF_FFFF_FFFF, 64'd1 << 32,
                    64'h7FFF_FFFF);
        send_particles(80, 32'h4000_0000);
        drain_results();
        load_config(0, 0, 64'd9 << 32, 64'd1 << 30, 64'd1 << 16);
        send_particles(80, 3 << 16);
        drain_results();
        load_config(64'd3 << 16, 2, 64'd4 << 32, 64'd3 << 31, 64'd5 << 16);
        send_particles(80, 2 << 16);
        drain_results();
        load_config(64'h7FFF_FFFF, 2, 64'd1 << 40, ONE_Q32 >> 8, 64'h7FFF_FFFF);
        send_particles(80, 64 << 16);
        drain_results();
    endtask

    task automatic test_idling_phases();
        load_typical(2);
        src_idle_pct = 0;  snk_stall_pct = 0;
        send_particles(260, 5 << 16);
        src_idle_pct = 75; snk_stall_pct = 0;
        send_particles(260, 5 << 16);
        src_idle_pct = 0;  snk_stall_pct = 75;
        send_particles(260, 5 << 16);
        src_idle_pct = 35; snk_stall_pct = 35;
        send_particles(260, 5 << 16);
        drain_results();
    endtask

    task automatic test_receiver_hold();
        src_idle_pct = 0;
        snk_stall_pct = 20;
        hold_req = 1;
        send_particles(40, 4 << 16);
        drain_results();
        send_particles(60, 4 << 16);
        drain_results();
    endtask

    initial begin
        in_ch.valid = 1'b0;
        in_ch.self_x = '0;
        in_ch.self_y = '0;
        in_ch.neighbor_x = '0;
        in_ch.neighbor_y = '0;
        in_ch.self_index = '0;
        in_ch.neighbor_index = '0;
        in_ch.pair_present = 1'b0;
        in_ch.last_neighbor = 1'b0;
        in_ch.last_particle = 1'b0;
        out_ch.ready = 1'b0;
        m_domain = '0;
        m_mode = 2'd2;
        m_cutoff = '0;
        m_sigma = '0;
        m_depth = '0;
        m_particle_sum = 0;
        m_system_sum = 0;
        m_sat_seen = 0;
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_values();
        test_directed();
        test_boundary_modes();
        test_register_extremes();
        test_idling_phases();
        test_receiver_hold();

        if (error_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end
endmodule
`default_nettype wire
